// ===== rtl/rmf_pkg.sv =====
// ----------------------------------------------------------------------------
// Running median filter package
// Shared widths and the link record that passes between neighbouring cells.
// ----------------------------------------------------------------------------
package rmf_pkg;

	localparam int DATA_W = 16;
	// Ages run up to the largest supported window less one (thirty-one).
	localparam int AGE_W  = 5;

	typedef logic [DATA_W-1:0] sample_t;
	typedef logic [AGE_W-1:0]  age_t;

	// What a cell shows its neighbours in every cycle.
	typedef struct packed {
		sample_t value;
		age_t    age;
		logic    gt;     // stored value is greater than the incoming word
	} link_t;

endpackage

// ===== rtl/rmf_cell.sv =====
// ----------------------------------------------------------------------------
// Running median filter cell
// One place of the sorted chain: a sample with its age, rebuilt every update.
// ----------------------------------------------------------------------------
module rmf_cell #(
	parameter int   WINDOW   = 5,
	parameter bit   FIRST    = 1'b0,
	parameter bit   LAST     = 1'b0,
	parameter int   INIT_AGE = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  rmf_pkg::sample_t x,
	input  rmf_pkg::link_t   left,
	input  rmf_pkg::link_t   right,
	input  logic             old_left,   // the evicted entry lies left of this cell
	output rmf_pkg::link_t   link,
	output logic             old_out,    // the evicted entry lies at or left of here
	output rmf_pkg::sample_t next_value
);

	localparam rmf_pkg::age_t OLDEST = rmf_pkg::age_t'(WINDOW - 1);

	rmf_pkg::sample_t value_q;
	rmf_pkg::age_t    age_q;
	rmf_pkg::age_t    next_age;
	logic             is_old;
	logic             gt;
	logic             evict_right;
	logic             evict_here_or_right;
	rmf_pkg::link_t   own;   // entry i of the list with the evicted entry removed
	rmf_pkg::link_t   prev;  // entry i-1 of that list

	assign is_old = (age_q == OLDEST);
	assign gt     = ($signed(value_q) > $signed(x));
	assign link   = '{value: value_q, age: age_q, gt: gt};
	assign old_out = old_left | is_old;

	assign evict_right         = !old_left && !is_old;
	assign evict_here_or_right = !old_left;

	assign own  = evict_right ? link : right;
	assign prev = evict_here_or_right ? left : link;

	// Keep entry i while it is no greater than the new word, then place the new word
	// at the first greater entry, and shift the rest one place right.
	always_comb begin
		priority if (!LAST && !own.gt) begin
			next_value = own.value;
			next_age   = own.age + rmf_pkg::age_t'(1);
		end else if (FIRST || !prev.gt) begin
			next_value = x;
			next_age   = '0;
		end else begin
			next_value = prev.value;
			next_age   = prev.age + rmf_pkg::age_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			age_q   <= rmf_pkg::age_t'(INIT_AGE);
		end else if (en) begin
			value_q <= next_value;
			age_q   <= next_age;
		end
	end

endmodule

// ===== rtl/running_median_filter_top.sv =====
// ----------------------------------------------------------------------------
// Running median filter, top level
// Sliding-window median of a signed sample stream, kept as a sorted cell chain.
// ----------------------------------------------------------------------------
// Output: the median of a word is registered as the word is taken and shows in the next cycle.
// Throughput: one word per cycle unless m_tready stalls; one compare-and-shift step
// of the cell chain is the whole update, so the output register alone paces it.
// Reset: arst_n clears the window to zeros with staggered ages and empties the
// output register; the first medians therefore count the zero entries.
// ----------------------------------------------------------------------------
module running_median_filter_top #(
	parameter int WINDOW = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [15:0] median
);

	localparam int MID = WINDOW >> 1;

	// The chain holds the window sorted ascending, each entry tagged with its age.
	// On each accepted word the entry whose age has reached WINDOW-1 is dropped,
	// the word is inserted at its sorted place and all other ages advance by one.
	// Every cell decides its new contents from itself and its two neighbours, plus
	// a single ripple flag that tells it whether the dropped entry lies to its left.

	rmf_pkg::link_t   links    [WINDOW];
	logic             old_chain[WINDOW];
	rmf_pkg::sample_t next_val [WINDOW];

	logic  take;
	logic  m_tvalid_q;
	logic [15:0] median_q;

	// The output register parts the two sides: a new word is taken whenever the
	// previous median has gone or is leaving in this same cycle.
	assign s_tready = !m_tvalid_q || m_tready;
	assign take     = s_tvalid && s_tready;

	genvar i;
	generate
		for (i = 0; i < WINDOW; i++) begin : g_cell
			rmf_pkg::link_t left_link;
			rmf_pkg::link_t right_link;
			logic           old_in;

			if (i == 0) begin : g_first
				assign left_link = '0;
				assign old_in    = 1'b0;
			end else begin : g_mid_left
				assign left_link = links[i-1];
				assign old_in    = old_chain[i-1];
			end

			if (i == WINDOW - 1) begin : g_last
				assign right_link = '0;
			end else begin : g_mid_right
				assign right_link = links[i+1];
			end

			rmf_cell #(
				.WINDOW  (WINDOW),
				.FIRST   (i == 0),
				.LAST    (i == WINDOW - 1),
				.INIT_AGE(WINDOW - 1 - i)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (take),
				.x         (s_tdata),
				.left      (left_link),
				.right     (right_link),
				.old_left  (old_in),
				.link      (links[i]),
				.old_out   (old_chain[i]),
				.next_value(next_val[i])
			);
		end
	endgenerate

	// The median is the middle cell's new value, captured with the update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			median_q <= next_val[MID];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = median_q;

endmodule
